// File: rtl/ssef_pkg.sv
package ssef_pkg;

	// Number formats
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int STEP_WIDTH = 24;
	localparam int STEP_FRAC  = 24;

	// Shared multiplier: both operands signed, one bit wider than a sample so that
	// the unsigned step size and the unsigned low part of d both fit.
	localparam int MUL_W  = DATA_WIDTH + 1;
	localparam int PROD_W = 2 * MUL_W;
	// d holds u less three coefficient terms; the accumulator also holds x2 + h*d.
	localparam int D_W    = 2 * DATA_WIDTH - FRAC_BITS + 2;
	localparam int ACC_W  = 2 * DATA_WIDTH - FRAC_BITS + 4;
	// Shift that places h * d_hi, where d_hi carries weight 2^DATA_WIDTH.
	localparam int UP_SHIFT = DATA_WIDTH - STEP_FRAC;

	localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(16777);

	// Sequencer step numbering
	localparam int STEP_CNT_W = 4;
	localparam logic [STEP_CNT_W-1:0] LAST_ISSUE = STEP_CNT_W'(8);
	localparam logic [STEP_CNT_W-1:0] DRAIN_STEP = STEP_CNT_W'(9);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A0,
		REG_A1,
		REG_A2,
		REG_B0,
		REG_B1,
		REG_STEP
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] a0;
		logic [DATA_WIDTH-1:0] a1;
		logic [DATA_WIDTH-1:0] a2;
		logic [DATA_WIDTH-1:0] b0;
		logic [DATA_WIDTH-1:0] b1;
		logic [STEP_WIDTH-1:0] h;
	} coef_t;

	typedef enum logic [2:0] {
		A_B0,
		A_B1,
		A_A0,
		A_A1,
		A_A2,
		A_H
	} a_sel_t;

	typedef enum logic [2:0] {
		B_X0,
		B_X1,
		B_X2,
		B_DLO,
		B_DHI
	} b_sel_t;

	typedef enum logic [1:0] {
		SH_FRAC,
		SH_STEP,
		SH_UP
	} shift_t;

	typedef enum logic [2:0] {
		BASE_ACC,
		BASE_ZERO,
		BASE_U,
		BASE_X0,
		BASE_X1,
		BASE_X2
	} base_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_Y,
		WB_D,
		WB_X0,
		WB_X1,
		WB_X2
	} wb_t;

	typedef struct packed {
		logic   valid;
		a_sel_t a_sel;
		b_sel_t b_sel;
		shift_t shift;
		base_t  base;
		logic   sub;
		wb_t    wb;
	} step_ctl_t;

	typedef struct packed {
		logic idle;
		logic finish;
	} seq_stat_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] sample;
		logic                  sat;
	} dp_res_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] val;
		logic                  hit;
	} clip_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} seq_state_t;

	localparam step_ctl_t CTL_NOP = '{valid: 1'b0, a_sel: A_B0, b_sel: B_X0, shift: SH_FRAC,
		base: BASE_ACC, sub: 1'b0, wb: WB_NONE};

	// Micro-program: one multiply per step, accumulated in the following cycle.
	function automatic step_ctl_t step_ctl(input logic [STEP_CNT_W-1:0] step);
		step_ctl_t c;
		c = CTL_NOP;
		c.valid = 1'b1;
		case (step)
			4'd0: begin
				c.a_sel = A_B0; c.b_sel = B_X0; c.shift = SH_FRAC; c.base = BASE_ZERO;
			end
			4'd1: begin
				c.a_sel = A_B1; c.b_sel = B_X1; c.shift = SH_FRAC; c.base = BASE_ACC;
				c.wb = WB_Y;
			end
			4'd2: begin
				c.a_sel = A_A0; c.b_sel = B_X0; c.shift = SH_FRAC; c.base = BASE_U;
				c.sub = 1'b1;
			end
			4'd3: begin
				c.a_sel = A_A1; c.b_sel = B_X1; c.shift = SH_FRAC; c.base = BASE_ACC;
				c.sub = 1'b1;
			end
			4'd4: begin
				c.a_sel = A_A2; c.b_sel = B_X2; c.shift = SH_FRAC; c.base = BASE_ACC;
				c.sub = 1'b1; c.wb = WB_D;
			end
			4'd5: begin
				c.a_sel = A_H; c.b_sel = B_X1; c.shift = SH_STEP; c.base = BASE_X0;
				c.wb = WB_X0;
			end
			4'd6: begin
				c.a_sel = A_H; c.b_sel = B_X2; c.shift = SH_STEP; c.base = BASE_X1;
				c.wb = WB_X1;
			end
			4'd7: begin
				c.a_sel = A_H; c.b_sel = B_DLO; c.shift = SH_STEP; c.base = BASE_X2;
			end
			4'd8: begin
				c.a_sel = A_H; c.b_sel = B_DHI; c.shift = SH_UP; c.base = BASE_ACC;
				c.wb = WB_X2;
			end
			default: begin
				c = CTL_NOP;
			end
		endcase
		return c;
	endfunction

	// Saturate an accumulator value to the sample range.
	function automatic clip_t clip_acc(input logic [ACC_W-1:0] acc);
		clip_t                     r;
		logic [ACC_W-DATA_WIDTH:0] upper;
		upper = acc[ACC_W-1:DATA_WIDTH-1];
		r.hit = !((&upper) || !(|upper));
		if (!r.hit) begin
			r.val = acc[DATA_WIDTH-1:0];
		end else if (acc[ACC_W-1]) begin
			r.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			r.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: rtl/ssef_if.sv
interface ssef_in_if;
	import ssef_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] sample_in;
	logic                  restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface ssef_out_if;
	import ssef_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] sample_out;
	logic                  saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// File: rtl/third_order_state_space_euler_filter.sv
// Third-order state-space filter in controllable canonical form, advanced by one
// forward Euler step for every input sample.
//
// Channels: in_ch carries the excitation sample and a restart bit; out_ch returns
// the output sample and a flag that is set when any state value or the output had
// to be clipped during that step. Both use a valid/ready transfer. The user must
// write coefficients and step size via cfg_we/cfg_index/cfg_data only while the
// block is idle, which is not enforced. An index past REG_STEP is ignored.
//
// Sequencing: one shared 33 x 33 multiplier performs nine products per sample,
// with the accumulator working on each product in the cycle after it. The block
// takes no new sample until the result has been handed to the output register;
// the result becomes valid at the same edge at which in_ch.ready returns.
//
// Reset clears the state, the coefficients (step size returns to about 0.001) and
// the output valid flag. When the receiver stalls, a finished result waits in the
// datapath until the output register is free, and no new sample is taken meanwhile.
module third_order_state_space_euler_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	ssef_in_if.sink                             in_ch,
	ssef_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [ssef_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssef_pkg::DATA_WIDTH-1:0]     cfg_data
);
	import ssef_pkg::*;

	coef_t                 coef_q;
	step_ctl_t             ctl;
	seq_stat_t             stat;
	dp_res_t               res;
	logic                  in_fire;
	logic                  out_free;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] sample_out_q;
	logic                  sat_out_q;

	assign in_ch.ready = stat.idle;
	assign in_fire     = in_ch.valid && stat.idle;
	// The output register can take a new result when it is empty or being emptied.
	assign out_free    = !out_valid_q || out_ch.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a0 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
			coef_q.b0 <= '0;
			coef_q.b1 <= '0;
			coef_q.h  <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A0:   coef_q.a0 <= cfg_data;
				REG_A1:   coef_q.a1 <= cfg_data;
				REG_A2:   coef_q.a2 <= cfg_data;
				REG_B0:   coef_q.b0 <= cfg_data;
				REG_B1:   coef_q.b1 <= cfg_data;
				REG_STEP: coef_q.h  <= cfg_data[STEP_WIDTH-1:0];
				default:  coef_q    <= coef_q;
			endcase
		end
	end

	ssef_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.out_free (out_free),
		.ctl      (ctl),
		.stat     (stat)
	);

	ssef_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.restart (in_ch.restart),
		.sample  (in_ch.sample_in),
		.coef    (coef_q),
		.ctl     (ctl),
		.res     (res)
	);

	// Output register: decouples the finished result from the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.finish) begin
			sample_out_q <= res.sample;
			sat_out_q    <= res.sat;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = sample_out_q;
	assign out_ch.saturated  = sat_out_q;

	// A transfer in starts the sequence, so the block is busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> !in_ch.ready)
		else $error("input taken while the sequence was running");

	// A result is only handed over when the output register has room for it.
	assert property (@(posedge clk) disable iff (!arst_n) stat.finish |-> out_free)
		else $error("result handed over while the output register was full");

	assert property (@(posedge clk) disable iff (!arst_n) stat.finish |=> out_valid_q)
		else $error("finished result not presented on the output");

	// The sequencer never finishes while a new sample is being accepted.
	assert property (@(posedge clk) disable iff (!arst_n) !(stat.finish && in_fire))
		else $error("result hand-over and input transfer in the same cycle");

endmodule

// File: rtl/ssef_seq.sv
module ssef_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  out_free,
	output ssef_pkg::step_ctl_t   ctl,
	output ssef_pkg::seq_stat_t   stat
);
	import ssef_pkg::*;

	seq_state_t            state_q;
	seq_state_t            state_next;
	logic [STEP_CNT_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_RUN) begin
				step_q <= step_q + STEP_CNT_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_RUN;
			end
			ST_RUN: begin
				if (step_q == DRAIN_STEP) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl         = CTL_NOP;
		stat.idle   = 1'b0;
		stat.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				stat.idle = 1'b1;
			end
			ST_RUN: begin
				if (step_q <= LAST_ISSUE) ctl = step_ctl(step_q);
			end
			ST_DONE: begin
				stat.finish = out_free;
			end
			default: begin
				ctl = CTL_NOP;
			end
		endcase
	end

endmodule

// File: rtl/ssef_dp.sv
module ssef_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                restart,
	input  logic [ssef_pkg::DATA_WIDTH-1:0]     sample,
	input  ssef_pkg::coef_t                     coef,
	input  ssef_pkg::step_ctl_t                 ctl,
	output ssef_pkg::dp_res_t                   res
);
	import ssef_pkg::*;

	logic [DATA_WIDTH-1:0]   x0_q, x1_q, x2_q;
	logic [DATA_WIDTH-1:0]   u_q;
	logic [DATA_WIDTH-1:0]   y_q;
	logic [D_W-1:0]          d_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    sat_q;
	logic signed [MUL_W-1:0] a_op, b_op;
	logic signed [PROD_W-1:0] prod, prod_s1, shifted;
	step_ctl_t               ctl_s1;
	logic [ACC_W-1:0]        term, base, acc_next;
	clip_t                   clip;

	// Operand selection and the shared multiplier.
	always_comb begin
		case (ctl.a_sel)
			A_B0:    a_op = MUL_W'($signed(coef.b0));
			A_B1:    a_op = MUL_W'($signed(coef.b1));
			A_A0:    a_op = MUL_W'($signed(coef.a0));
			A_A1:    a_op = MUL_W'($signed(coef.a1));
			A_A2:    a_op = MUL_W'($signed(coef.a2));
			A_H:     a_op = $signed(MUL_W'(coef.h));
			default: a_op = '0;
		endcase
		case (ctl.b_sel)
			B_X0:    b_op = MUL_W'($signed(x0_q));
			B_X1:    b_op = MUL_W'($signed(x1_q));
			B_X2:    b_op = MUL_W'($signed(x2_q));
			B_DLO:   b_op = $signed({1'b0, d_q[DATA_WIDTH-1:0]});
			B_DHI:   b_op = MUL_W'($signed(d_q[D_W-1:DATA_WIDTH]));
			default: b_op = '0;
		endcase
	end

	assign prod = a_op * b_op;

	// Accumulate stage: scale the registered product and add it to the chosen base.
	always_comb begin
		case (ctl_s1.shift)
			SH_FRAC: shifted = prod_s1 >>> FRAC_BITS;
			SH_STEP: shifted = prod_s1 >>> STEP_FRAC;
			SH_UP:   shifted = prod_s1 <<< UP_SHIFT;
			default: shifted = '0;
		endcase
		term = shifted[ACC_W-1:0];
		case (ctl_s1.base)
			BASE_ACC:  base = acc_q;
			BASE_ZERO: base = '0;
			BASE_U:    base = ACC_W'($signed(u_q));
			BASE_X0:   base = ACC_W'($signed(x0_q));
			BASE_X1:   base = ACC_W'($signed(x1_q));
			BASE_X2:   base = ACC_W'($signed(x2_q));
			default:   base = '0;
		endcase
		acc_next = ctl_s1.sub ? base - term : base + term;
		clip     = clip_acc(acc_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q   <= '0;
			x1_q   <= '0;
			x2_q   <= '0;
			sat_q  <= 1'b0;
			ctl_s1 <= CTL_NOP;
		end else begin
			ctl_s1 <= ctl;
			if (start) begin
				sat_q <= 1'b0;
				if (restart) begin
					x0_q <= '0;
					x1_q <= '0;
					x2_q <= '0;
				end
			end else if (ctl_s1.valid) begin
				case (ctl_s1.wb)
					WB_Y: sat_q <= sat_q | clip.hit;
					WB_X0: begin
						x0_q  <= clip.val;
						sat_q <= sat_q | clip.hit;
					end
					WB_X1: begin
						x1_q  <= clip.val;
						sat_q <= sat_q | clip.hit;
					end
					WB_X2: begin
						x2_q  <= clip.val;
						sat_q <= sat_q | clip.hit;
					end
					default: begin
						sat_q <= sat_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) u_q <= sample;
		if (ctl.valid) prod_s1 <= prod;
		if (ctl_s1.valid) begin
			acc_q <= acc_next;
			if (ctl_s1.wb == WB_Y) y_q <= clip.val;
			if (ctl_s1.wb == WB_D) d_q <= acc_next[D_W-1:0];
		end
	end

	assign res.sample = y_q;
	assign res.sat    = sat_q;

endmodule
